// ===== hdl/tunnel_replay_window_filter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Replay window filter assertion macros
// Property wrappers used by the top level; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TUNNEL_REPLAY_WINDOW_FILTER_TOP_MACROS_SVH
`define TUNNEL_REPLAY_WINDOW_FILTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TRWF_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("replay filter check failed");
// next-cycle implication
`define TRWF_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("replay filter check failed");
`else
`define TRWF_CHK_NOW(lbl, ante, cons)
`define TRWF_CHK_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/trwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Replay window filter package
// Shared widths, codes, request types and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package trwf_pkg;

    // default sizing
    localparam int unsigned PEER_COUNT_DEF   = 32;
    localparam int unsigned SEQ_SLOTS_DEF    = 1024;
    localparam int unsigned COUNTER_BITS_DEF = 32;

    // field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SEQ_W   = 10;
    localparam int unsigned PEER_W  = 5;
    localparam int unsigned VERD_W  = 4;
    localparam int unsigned CNTO_W  = 32;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 16;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_RESET_INTERVAL = 3'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_DELAY      = 3'd1;
    localparam logic [CIDX_W-1:0] REG_JUMP_LIMIT     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_INVOLVE_LIMIT  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_REPLAY_LIMIT   = 3'd4;

    // register reset values
    localparam logic [15:0] RST_RESET_INTERVAL = 16'd60;
    localparam logic [15:0] RST_MAX_DELAY      = 16'd10;
    localparam logic [7:0]  RST_JUMP_LIMIT     = 8'd3;
    localparam logic [7:0]  RST_INVOLVE_LIMIT  = 8'd3;
    localparam logic [7:0]  RST_REPLAY_LIMIT   = 8'd3;

    // verdict codes
    localparam logic [VERD_W-1:0] VERD_BAD            = 4'd0;
    localparam logic [VERD_W-1:0] VERD_DUP            = 4'd1;
    localparam logic [VERD_W-1:0] VERD_LATE           = 4'd2;
    localparam logic [VERD_W-1:0] VERD_JUMP_INVOLVE   = 4'd3;
    localparam logic [VERD_W-1:0] VERD_JUMP_LOG       = 4'd4;
    localparam logic [VERD_W-1:0] VERD_JUMP_EXCEED    = 4'd5;
    localparam logic [VERD_W-1:0] VERD_REPLAY_INVOLVE = 4'd6;
    localparam logic [VERD_W-1:0] VERD_REPLAY_LOG     = 4'd7;
    localparam logic [VERD_W-1:0] VERD_REPLAY_EXCEED  = 4'd8;
    localparam logic [VERD_W-1:0] VERD_PREV_SEC       = 4'd9;
    localparam logic [VERD_W-1:0] VERD_SAME_SEC       = 4'd10;
    localparam logic [VERD_W-1:0] VERD_NEXT_SEC       = 4'd11;
    localparam logic [VERD_W-1:0] VERD_RESYNC         = 4'd12;

    // bitmap work selected after classification
    localparam logic [1:0] PATH_DONE    = 2'd0;
    localparam logic [1:0] PATH_CHECK   = 2'd1;
    localparam logic [1:0] PATH_RESYNC  = 2'd2;
    localparam logic [1:0] PATH_ADVANCE = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] packet_time;
        logic [SEQ_W-1:0]  packet_seq;
        logic [PEER_W-1:0] source_peer;
        logic [PEER_W-1:0] dest_peer;
    } t_in_req;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic [CNTO_W-1:0] jump_count;
        logic [CNTO_W-1:0] replay_count;
        logic [CNTO_W-1:0] dup_count;
        logic [CNTO_W-1:0] late_count;
        logic [CNTO_W-1:0] involve_count;
    } t_out_req;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic step_t1;
        logic step_t2;
        logic step_t3;
        logic bm_check;
        logic clr_init;
        logic clr_step;
        logic bm_set;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       bad;
        logic [1:0] path;
        logic       clr_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/trwf_bitmap.sv =====
// ----------------------------------------------------------------------------
// Sequence bitmap memory
// Single-port 64-bit word store, registered read, read-before-write.
// ----------------------------------------------------------------------------
`default_nettype none

module trwf_bitmap #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [63:0]   i_wdata,
    output logic      [63:0]   o_rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] r_rdata;

    // write and registered read on one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/trwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Replay window filter controller
// Sequences fetch, classify, bitmap check/clear/set and write-back per request.
// ----------------------------------------------------------------------------
`default_nettype none

module trwf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic            i_out_stall,
    output logic                 o_out_valid,
    input  wire trwf_pkg::t_sts  i_sts,
    output trwf_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_FETCH = 4'd2;
    localparam logic [3:0] ST_T1    = 4'd3;
    localparam logic [3:0] ST_T2    = 4'd4;
    localparam logic [3:0] ST_T3    = 4'd5;
    localparam logic [3:0] ST_BRD   = 4'd6;
    localparam logic [3:0] ST_BCK   = 4'd7;
    localparam logic [3:0] ST_CLR   = 4'd8;
    localparam logic [3:0] ST_SET   = 4'd9;
    localparam logic [3:0] ST_WB    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.clr_init = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.load = accept;
                if (accept) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = i_sts.bad ? ST_WB : ST_T1;
            end
            ST_T1: begin
                o_cmd.step_t1 = 1'b1;
                n_state = ST_T2;
            end
            ST_T2: begin
                o_cmd.step_t2 = 1'b1;
                n_state = ST_T3;
            end
            ST_T3: begin
                o_cmd.step_t3 = 1'b1;
                case (i_sts.path)
                    trwf_pkg::PATH_CHECK: n_state = ST_BRD;
                    trwf_pkg::PATH_RESYNC,
                    trwf_pkg::PATH_ADVANCE: n_state = ST_CLR;
                    default: n_state = ST_WB;
                endcase
            end
            ST_BRD: begin
                n_state = ST_BCK;
            end
            ST_BCK: begin
                o_cmd.bm_check = 1'b1;
                n_state = ST_WB;
            end
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_SET;
            end
            ST_SET: begin
                o_cmd.bm_set = 1'b1;
                n_state = ST_WB;
            end
            ST_WB: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output valid: set by commit, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/trwf_dpath.sv =====
// ----------------------------------------------------------------------------
// Replay window filter datapath
// Peer records, configuration, per-stage arithmetic, bitmap addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module trwf_dpath #(
    parameter int unsigned PEER_COUNT   = trwf_pkg::PEER_COUNT_DEF,
    parameter int unsigned SEQ_SLOTS    = trwf_pkg::SEQ_SLOTS_DEF,
    parameter int unsigned COUNTER_BITS = trwf_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire trwf_pkg::t_in_req             i_in_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [trwf_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  wire logic [trwf_pkg::CDATA_W-1:0]  i_cfg_data,
    input  wire trwf_pkg::t_cmd                i_cmd,
    output trwf_pkg::t_sts                     o_sts,
    output trwf_pkg::t_out_req                 o_out_req
);

    localparam int unsigned PW    = $clog2(PEER_COUNT);
    localparam int unsigned WORDS = (SEQ_SLOTS + 63) / 64;
    localparam int unsigned DEPTH = PEER_COUNT * 2 * WORDS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CNTW  = $clog2(DEPTH + 1);
    localparam int unsigned CB    = COUNTER_BITS;
    localparam logic [CNTW-1:0] LIM_INIT = CNTW'(DEPTH - 1);
    localparam logic [CNTW-1:0] LIM_BOTH = CNTW'(2 * WORDS - 1);
    localparam logic [CNTW-1:0] LIM_ONE  = CNTW'(WORDS - 1);

    typedef struct packed {
        logic [31:0]   time_low;
        logic [31:0]   time_high;
        logic [31:0]   cur_sec;
        logic [CB-1:0] jumps;
        logic [CB-1:0] replays;
        logic [CB-1:0] dup_cnt;
        logic [CB-1:0] late_cnt;
        logic          bank;
    } t_rec;

    // configuration
    logic [15:0] r_reset_interval;
    logic [15:0] r_max_delay;
    logic [7:0]  r_jump_limit;
    logic [7:0]  r_involve_limit;
    logic [7:0]  r_replay_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_interval <= trwf_pkg::RST_RESET_INTERVAL;
            r_max_delay      <= trwf_pkg::RST_MAX_DELAY;
            r_jump_limit     <= trwf_pkg::RST_JUMP_LIMIT;
            r_involve_limit  <= trwf_pkg::RST_INVOLVE_LIMIT;
            r_replay_limit   <= trwf_pkg::RST_REPLAY_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                trwf_pkg::REG_RESET_INTERVAL: r_reset_interval <= i_cfg_data;
                trwf_pkg::REG_MAX_DELAY:      r_max_delay      <= i_cfg_data;
                trwf_pkg::REG_JUMP_LIMIT:     r_jump_limit     <= i_cfg_data[7:0];
                trwf_pkg::REG_INVOLVE_LIMIT:  r_involve_limit  <= i_cfg_data[7:0];
                trwf_pkg::REG_REPLAY_LIMIT:   r_replay_limit   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // working registers
    trwf_pkg::t_in_req            r_req;
    t_rec                         r_rec;
    logic [CB-1:0]                r_inv;
    logic                         r_inv_we;
    logic                         r_bad;
    logic                         r_jevt;
    logic [31:0]                  r_diff;
    logic                         r_prev;
    logic [1:0]                   r_path;
    logic [trwf_pkg::VERD_W-1:0]  r_verdict;
    logic [CNTW-1:0]              r_cnt;
    trwf_pkg::t_out_req           r_out;

    // peer tables
    t_rec          rec_mem [PEER_COUNT];
    logic [CB-1:0] inv_mem [PEER_COUNT];

    logic [PW-1:0] pidx;
    logic [PW-1:0] didx;
    logic          bad;
    assign pidx = PW'(r_req.source_peer);
    assign didx = PW'(r_req.dest_peer);
    assign bad  = (r_req.source_peer == r_req.dest_peer) || (r_req.source_peer == '0)
               || (32'(r_req.source_peer) >= PEER_COUNT)
               || (32'(r_req.dest_peer) >= PEER_COUNT);

    // time spread and offset
    logic [31:0] t1_low;
    logic [31:0] t1_high;
    logic        t2_jevt;
    assign t1_low  = (r_rec.time_low == '0 || r_req.packet_time < r_rec.time_low)
                   ? r_req.packet_time : r_rec.time_low;
    assign t1_high = (r_rec.time_high == '0 || r_req.packet_time > r_rec.time_high)
                   ? r_req.packet_time : r_rec.time_high;
    assign t2_jevt = (r_rec.time_high - r_rec.time_low)
                   > (32'(r_reset_interval) + 32'(r_max_delay));

    // classification
    logic [CB-1:0] rep_new;
    logic [CB-1:0] inv_new;
    logic          inv_hit;
    logic          inv_over;
    logic          rep_over;
    logic          d_ge2;
    logic          d_one;
    logic          d_zero;
    logic          d_m1;
    logic          d_late;
    logic [32:0]   late_sum;
    logic [1:0]    c_path;

    assign rep_new  = r_rec.replays + 1'b1;
    assign inv_new  = r_inv + 1'b1;
    assign inv_hit  = r_req.source_peer < r_req.dest_peer;
    assign inv_over = 32'(inv_new) > 32'(r_involve_limit);
    assign rep_over = 32'(r_rec.replays) >= 32'(r_replay_limit);
    assign d_ge2    = !r_diff[31] && (r_diff >= 32'd2);
    assign d_one    = (r_diff == 32'd1);
    assign d_zero   = (r_diff == 32'd0);
    assign d_m1     = (r_diff == '1);
    assign late_sum = {r_diff[31], r_diff} + {17'd0, r_max_delay};
    assign d_late   = !late_sum[32] && (late_sum != '0);

    always_comb begin
        if ((r_jevt && 32'(r_rec.jumps) == 32'(r_jump_limit))
            || 32'(r_rec.jumps) >= 32'(r_jump_limit)) begin
            c_path = trwf_pkg::PATH_DONE;
        end else if (d_ge2) begin
            c_path = trwf_pkg::PATH_RESYNC;
        end else if (d_one) begin
            c_path = trwf_pkg::PATH_ADVANCE;
        end else if (d_zero || d_m1) begin
            c_path = trwf_pkg::PATH_CHECK;
        end else if (d_late) begin
            c_path = trwf_pkg::PATH_DONE;
        end else if (32'(rep_new) >= 32'(r_replay_limit)) begin
            c_path = trwf_pkg::PATH_DONE;
        end else begin
            c_path = trwf_pkg::PATH_RESYNC;
        end
    end

    // bitmap addressing
    logic [63:0]   bm_rdata;
    logic [63:0]   bm_wdata;
    logic [63:0]   onehot;
    logic [AW-1:0] bm_addr;
    logic [AW-1:0] tgt_addr;
    logic [AW-1:0] clr_base;
    logic          bm_we;
    logic          seq_ok;
    logic          bit_set;
    logic [CNTW-1:0] clr_lim;

    assign seq_ok   = 32'(r_req.packet_seq) < SEQ_SLOTS;
    assign onehot   = 64'd1 << r_req.packet_seq[5:0];
    assign bit_set  = seq_ok && bm_rdata[r_req.packet_seq[5:0]];
    assign tgt_addr = AW'(AW'({pidx, r_rec.bank ^ r_prev}) * AW'(WORDS))
                    + AW'(r_req.packet_seq >> 6);
    assign clr_base = (r_path == trwf_pkg::PATH_RESYNC)
                    ? AW'(AW'({pidx, 1'b0}) * AW'(WORDS))
                    : AW'(AW'({pidx, r_rec.bank}) * AW'(WORDS));
    assign clr_lim  = i_cmd.clr_init ? LIM_INIT
                    : ((r_path == trwf_pkg::PATH_RESYNC) ? LIM_BOTH : LIM_ONE);

    always_comb begin
        if (i_cmd.clr_init) begin
            bm_addr = AW'(r_cnt);
        end else if (i_cmd.clr_step) begin
            bm_addr = clr_base + AW'(r_cnt);
        end else begin
            bm_addr = tgt_addr;
        end
    end

    assign bm_we    = i_cmd.clr_init || i_cmd.clr_step || (i_cmd.bm_set && seq_ok)
                   || (i_cmd.bm_check && seq_ok && !bit_set);
    assign bm_wdata = (i_cmd.clr_init || i_cmd.clr_step) ? 64'd0
                    : (i_cmd.bm_set ? onehot : (bm_rdata | onehot));

    trwf_bitmap #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_addr  (bm_addr),
        .i_wdata (bm_wdata),
        .o_rdata (bm_rdata)
    );

    // sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_init || i_cmd.clr_step) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_cnt <= '0;
        end
    end

    assign o_sts.bad      = bad;
    assign o_sts.path     = c_path;
    assign o_sts.clr_last = (r_cnt == clr_lim);

    // per-stage work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req;
        end
        if (i_cmd.fetch) begin
            r_rec     <= rec_mem[pidx];
            r_inv     <= inv_mem[didx];
            r_inv_we  <= 1'b0;
            r_prev    <= 1'b0;
            r_bad     <= bad;
            r_path    <= trwf_pkg::PATH_DONE;
            r_verdict <= trwf_pkg::VERD_BAD;
        end
        if (i_cmd.step_t1) begin
            r_rec.time_low  <= t1_low;
            r_rec.time_high <= t1_high;
        end
        if (i_cmd.step_t2) begin
            r_jevt <= t2_jevt;
            r_diff <= r_req.packet_time - r_rec.cur_sec;
            if (t2_jevt) begin
                r_rec.jumps     <= r_rec.jumps + 1'b1;
                r_rec.time_low  <= '0;
                r_rec.time_high <= '0;
            end
        end
        if (i_cmd.step_t3) begin
            r_path <= c_path;
            if (r_jevt && 32'(r_rec.jumps) == 32'(r_jump_limit)) begin
                if (inv_hit) begin
                    r_inv    <= inv_new;
                    r_inv_we <= 1'b1;
                end
                r_verdict <= (inv_hit && inv_over) ? trwf_pkg::VERD_JUMP_INVOLVE
                                                   : trwf_pkg::VERD_JUMP_LOG;
            end else if (32'(r_rec.jumps) >= 32'(r_jump_limit)) begin
                r_verdict <= trwf_pkg::VERD_JUMP_EXCEED;
            end else if (d_ge2) begin
                r_rec.cur_sec <= r_req.packet_time;
                r_verdict <= rep_over ? trwf_pkg::VERD_REPLAY_EXCEED : trwf_pkg::VERD_RESYNC;
            end else if (d_one) begin
                r_rec.cur_sec <= r_req.packet_time;
                r_rec.bank    <= ~r_rec.bank;
                r_verdict <= rep_over ? trwf_pkg::VERD_REPLAY_EXCEED
                                      : trwf_pkg::VERD_NEXT_SEC;
            end else if (d_zero || d_m1) begin
                r_prev <= d_m1;
            end else if (d_late) begin
                r_rec.late_cnt <= r_rec.late_cnt + 1'b1;
                r_verdict <= trwf_pkg::VERD_LATE;
            end else begin
                r_rec.replays <= rep_new;
                if (32'(rep_new) == 32'(r_replay_limit)) begin
                    if (inv_hit) begin
                        r_inv    <= inv_new;
                        r_inv_we <= 1'b1;
                    end
                    r_verdict <= (inv_hit && inv_over) ? trwf_pkg::VERD_REPLAY_INVOLVE
                                                       : trwf_pkg::VERD_REPLAY_LOG;
                end else if (32'(rep_new) > 32'(r_replay_limit)) begin
                    r_verdict <= trwf_pkg::VERD_REPLAY_EXCEED;
                end else begin
                    r_rec.cur_sec <= r_req.packet_time;
                    r_verdict <= trwf_pkg::VERD_RESYNC;
                end
            end
        end
        if (i_cmd.bm_check) begin
            if (bit_set) begin
                r_rec.dup_cnt <= r_rec.dup_cnt + 1'b1;
                r_verdict <= trwf_pkg::VERD_DUP;
            end else if (rep_over) begin
                r_verdict <= trwf_pkg::VERD_REPLAY_EXCEED;
            end else begin
                r_verdict <= r_prev ? trwf_pkg::VERD_PREV_SEC : trwf_pkg::VERD_SAME_SEC;
            end
        end
        // result register
        if (i_cmd.commit) begin
            if (r_bad) begin
                r_out <= '0;
            end else begin
                r_out.verdict       <= r_verdict;
                r_out.jump_count    <= 32'(r_rec.jumps);
                r_out.replay_count  <= 32'(r_rec.replays);
                r_out.dup_count     <= 32'(r_rec.dup_cnt);
                r_out.late_count    <= 32'(r_rec.late_cnt);
                r_out.involve_count <= 32'(r_inv);
            end
        end
    end

    // peer table write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PEER_COUNT; i++) begin
                rec_mem[i] <= '0;
                inv_mem[i] <= '0;
            end
        end else if (i_cmd.commit && !r_bad) begin
            rec_mem[pidx] <= r_rec;
            if (r_inv_we) inv_mem[didx] <= r_inv;
        end
    end

    assign o_out_req = r_out;

endmodule

`default_nettype wire

// ===== hdl/tunnel_replay_window_filter_top.sv =====
// ----------------------------------------------------------------------------
// Tunnel replay window filter
// Per-peer anti-replay check with two-second sliding sequence bitmaps.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_stall   i_in_req  (trwf_pkg::t_in_req)
//   out      output     o_out_valid/i_out_stall o_out_req (trwf_pkg::t_out_req)
//   cfg      input      i_cfg_we                i_cfg_idx, i_cfg_data
//
// One request at a time. Bad ids go from fetch straight to write-back; other
// verdicts are classified, then duplicate/same/previous second checks read
// the bitmap and a second advance or a resync clears bitmap words, one a
// cycle through the single bitmap memory port, then sets the sequence bit.
// The next request can be taken in the cycle after the result is written.
// After reset all PEER_COUNT*2*WORDS bitmap words are cleared before the
// first request is taken. A result waits in the output register while the
// next request is accepted; a stalled output holds the final write-back only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tunnel_replay_window_filter_top_macros.svh"

module tunnel_replay_window_filter_top #(
    parameter int unsigned PEER_COUNT   = trwf_pkg::PEER_COUNT_DEF,
    parameter int unsigned SEQ_SLOTS    = trwf_pkg::SEQ_SLOTS_DEF,
    parameter int unsigned COUNTER_BITS = trwf_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire trwf_pkg::t_in_req             i_in_req,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output trwf_pkg::t_out_req                 o_out_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [trwf_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  wire logic [trwf_pkg::CDATA_W-1:0]  i_cfg_data
);

    trwf_pkg::t_cmd cmd;
    trwf_pkg::t_sts sts;

    // sequencer
    trwf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // records, arithmetic, bitmaps
    trwf_dpath #(
        .PEER_COUNT   (PEER_COUNT),
        .SEQ_SLOTS    (SEQ_SLOTS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_req   (i_in_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_req  (o_out_req)
    );

    // checks
    `TRWF_CHK_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `TRWF_CHK_NOW(a_result_after_work, $rose(o_out_valid), $past(o_in_stall))
    `TRWF_CHK_NOW(a_bad_ids_zero, o_out_valid && o_out_req.verdict == trwf_pkg::VERD_BAD, o_out_req.jump_count == '0 && o_out_req.involve_count == '0 && o_out_req.dup_count == '0)

endmodule

`default_nettype wire
